/* hw/rtl/dmxtx_pkg.sv */
package dmxtx_pkg;

	// Slot store geometry
	localparam int MaxSlots = 513;
	localparam int SlotAw   = 10;

	// Item kinds carried on s_tuser
	localparam logic [1:0] OpTick  = 2'd0;
	localparam logic [1:0] OpWrite = 2'd1;
	localparam logic [1:0] OpStart = 2'd2;

	// Configuration register indexes
	localparam logic [7:0] RegSlotCount  = 8'd0;
	localparam logic [7:0] RegBitTicks   = 8'd1;
	localparam logic [7:0] RegBreakTicks = 8'd2;
	localparam logic [7:0] RegMabTicks   = 8'd3;

	// Register reset values
	localparam logic [9:0] SlotCountRst  = 10'd513;
	localparam logic [7:0] BitTicksRst   = 8'd4;
	localparam logic [9:0] BreakTicksRst = 10'd100;
	localparam logic [7:0] MabTicksRst   = 8'd12;

	typedef struct packed {
		logic [9:0] slot_count;
		logic [7:0] bit_ticks;
		logic [9:0] break_ticks;
		logic [7:0] mab_ticks;
	} cfg_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [SlotAw-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
		logic index_error;
	} result_t;

endpackage

/* hw/rtl/dmxtx_slot_ram.sv */
module dmxtx_slot_ram (
	input  logic                clk,
	input  dmxtx_pkg::mem_req_t req,
	output logic [7:0]          rdata
);

	logic [7:0] mem [0:dmxtx_pkg::MaxSlots-1];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

/* hw/rtl/dmxtx_seq.sv */
module dmxtx_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_en,
	input  logic [1:0]           operation,
	input  logic [9:0]           slot_index,
	input  logic [7:0]           slot_value,
	input  dmxtx_pkg::cfg_t      cfg,
	input  logic [7:0]           rdata,
	output dmxtx_pkg::mem_req_t  mem_req,
	output dmxtx_pkg::result_t   result
);

	localparam logic [2:0] PhIdle  = 3'd0;
	localparam logic [2:0] PhBreak = 3'd1;
	localparam logic [2:0] PhMab   = 3'd2;
	localparam logic [2:0] PhStart = 3'd3;
	localparam logic [2:0] PhData  = 3'd4;
	localparam logic [2:0] PhStop  = 3'd5;

	localparam logic [9:0] MaxSlotsC = 10'(dmxtx_pkg::MaxSlots);
	localparam logic [9:0] LastSlot  = 10'(dmxtx_pkg::MaxSlots - 1);

	logic [2:0] ph_q, ph_d;
	logic [9:0] tick_q, tick_d;
	logic [9:0] slot_q, slot_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic       ld_s1, ld_d;

	logic [7:0]  bt, mab;
	logic [9:0]  brk, eff;
	logic [10:0] t;
	logic [3:0]  bit_inc;
	logic [9:0]  slot_inc;
	logic [9:0]  ld_idx;
	logic        do_load;
	logic        lvl_cur;
	logic        done;

	// Effective durations and slot count
	always_comb begin
		bt  = (cfg.bit_ticks == 8'd0) ? 8'd1 : cfg.bit_ticks;
		mab = (cfg.mab_ticks == 8'd0) ? 8'd1 : cfg.mab_ticks;
		brk = (cfg.break_ticks == 10'd0) ? 10'd1 : cfg.break_ticks;
		if (cfg.slot_count == 10'd0) begin
			eff = 10'd1;
		end else if (cfg.slot_count > MaxSlotsC) begin
			eff = MaxSlotsC;
		end else begin
			eff = cfg.slot_count;
		end
	end

	// Level driven in the current phase
	always_comb begin
		unique case (ph_q)
			PhBreak: lvl_cur = 1'b0;
			PhStart: lvl_cur = 1'b0;
			PhData:  lvl_cur = shift_q[0];
			default: lvl_cur = 1'b1;
		endcase
	end

	// Next state, memory request and result
	always_comb begin
		ph_d     = ph_q;
		tick_d   = tick_q;
		slot_d   = slot_q;
		bit_d    = bit_q;
		shift_d  = ld_s1 ? rdata : shift_q;
		ld_d     = 1'b0;
		do_load  = 1'b0;
		ld_idx   = 10'd0;
		done     = 1'b0;
		t        = {1'b0, tick_q} + 11'd1;
		bit_inc  = bit_q + 4'd1;
		slot_inc = slot_q + 10'd1;
		mem_req  = '0;
		result   = '0;
		result.line_level = lvl_cur;

		if (item_en) begin
			unique case (operation)
				dmxtx_pkg::OpTick: begin
					if (ph_q != PhIdle) begin
						tick_d = t[9:0];
						unique case (ph_q)
							PhBreak: begin
								if (t >= {1'b0, brk}) begin
									ph_d   = PhMab;
									tick_d = 10'd0;
								end
							end
							PhMab: begin
								if (t >= {3'b0, mab}) begin
									slot_d  = 10'd0;
									ld_idx  = 10'd0;
									do_load = 1'b1;
								end
							end
							PhStart: begin
								if (t >= {3'b0, bt}) begin
									ph_d   = PhData;
									bit_d  = 4'd0;
									tick_d = 10'd0;
								end
							end
							PhData: begin
								if (t >= {3'b0, bt}) begin
									tick_d  = 10'd0;
									shift_d = {1'b0, shift_q[7:1]};
									bit_d   = bit_inc;
									if (bit_inc >= 4'd8) begin
										ph_d  = PhStop;
										bit_d = 4'd0;
									end
								end
							end
							PhStop: begin
								if (t >= {2'b0, bt, 1'b0}) begin
									if (slot_inc >= eff) begin
										ph_d   = PhIdle;
										tick_d = 10'd0;
										slot_d = 10'd0;
										done   = 1'b1;
									end else begin
										slot_d  = slot_inc;
										ld_idx  = slot_inc;
										do_load = 1'b1;
									end
								end
							end
							default: tick_d = 10'd0;
						endcase
					end else begin
						tick_d = 10'd0;
					end
				end
				dmxtx_pkg::OpWrite: begin
					if (slot_index >= eff) begin
						result.index_error = 1'b1;
					end else begin
						mem_req.wr_en = 1'b1;
						mem_req.addr  = slot_index;
						mem_req.wdata = slot_value;
					end
				end
				dmxtx_pkg::OpStart: begin
					if (ph_q == PhIdle) begin
						ph_d   = PhBreak;
						tick_d = 10'd0;
						slot_d = 10'd0;
						bit_d  = 4'd0;
						result.line_level = 1'b0;
					end
				end
				default: ;
			endcase
		end

		// Fetch the next slot byte; it reaches the shifter through the memory read register
		if (do_load) begin
			ph_d          = PhStart;
			tick_d        = 10'd0;
			bit_d         = 4'd0;
			ld_d          = 1'b1;
			mem_req.rd_en = 1'b1;
			mem_req.addr  = (ld_idx >= MaxSlotsC) ? LastSlot : ld_idx;
		end

		result.busy_res   = (ph_d != PhIdle);
		result.frame_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PhIdle;
			tick_q  <= 10'd0;
			slot_q  <= 10'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			ld_s1   <= 1'b0;
		end else begin
			ph_q    <= ph_d;
			tick_q  <= tick_d;
			slot_q  <= slot_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			ld_s1   <= ld_d;
		end
	end

endmodule

/* hw/rtl/dmx512_frame_transmitter.sv */
// DMX512 frame transmitter.
// Input requests arrive on s_tvalid/s_tready with the item kind on s_tuser:
// a tick advances the serial line by one time unit, a write stores a byte in
// the slot store (slot 0 is the start code), a start begins a frame (break,
// mark-after-break, then each slot as start bit, eight data bits LSB first
// and two stop bits). Every accepted request gives exactly one result on
// m_tvalid/m_tready: line level and busy in m_tdata, the end-of-frame mark on
// m_tlast and the bad-index flag on m_tuser.
// The result of each request appears in the output register the cycle after
// acceptance; one request is taken per cycle while the output is free or being
// drained and the clearing pass is done. A slot byte is fetched from the
// single-port slot memory on the tick that starts the slot and reaches the
// shifter through the memory read register.
// After reset the block clears the 513-entry slot store, one entry per cycle,
// and holds s_tready low until that pass is done; configuration writes on the
// cfg channel are taken at any time and reset restores the default timing.
// When the receiver stalls, the pending result is held and s_tready drops
// until it is taken.
module dmx512_frame_transmitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // slot_index[9:0], slot_value[17:10], zero pad
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // line_level[0], busy_res[1], zero pad
	output logic        m_tlast,   // frame_done
	output logic [0:0]  m_tuser,   // index_error[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam logic [9:0] LastSlot = 10'(dmxtx_pkg::MaxSlots - 1);

	dmxtx_pkg::cfg_t      cfg_q;
	dmxtx_pkg::mem_req_t  seq_req, ram_req;
	dmxtx_pkg::result_t   res, res_q;
	logic [7:0]           rdata;
	logic                 clearing_q;
	logic [9:0]           clr_q;
	logic                 in_fire;
	logic                 out_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !clearing_q && (!out_q || m_tready);
	assign in_fire   = s_tvalid && s_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slot_count  <= dmxtx_pkg::SlotCountRst;
			cfg_q.bit_ticks   <= dmxtx_pkg::BitTicksRst;
			cfg_q.break_ticks <= dmxtx_pkg::BreakTicksRst;
			cfg_q.mab_ticks   <= dmxtx_pkg::MabTicksRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dmxtx_pkg::RegSlotCount:  cfg_q.slot_count  <= cfg_data;
				dmxtx_pkg::RegBitTicks:   cfg_q.bit_ticks   <= cfg_data[7:0];
				dmxtx_pkg::RegBreakTicks: cfg_q.break_ticks <= cfg_data;
				dmxtx_pkg::RegMabTicks:   cfg_q.mab_ticks   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Clearing pass over the slot store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= 10'd0;
		end else if (clearing_q) begin
			clr_q <= clr_q + 10'd1;
			if (clr_q == LastSlot) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			ram_req.rd_en = 1'b0;
			ram_req.wr_en = 1'b1;
			ram_req.addr  = clr_q;
			ram_req.wdata = 8'd0;
		end else begin
			ram_req = seq_req;
		end
	end

	dmxtx_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_en    (in_fire),
		.operation  (s_tuser),
		.slot_index (s_tdata[9:0]),
		.slot_value (s_tdata[17:10]),
		.cfg        (cfg_q),
		.rdata      (rdata),
		.mem_req    (seq_req),
		.result     (res)
	);

	dmxtx_slot_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= 1'b0;
		end else if (in_fire) begin
			out_q <= 1'b1;
		end else if (m_tready) begin
			out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_q;
	assign m_tdata  = {6'd0, res_q.busy_res, res_q.line_level};
	assign m_tlast  = res_q.frame_done;
	assign m_tuser  = res_q.index_error;

endmodule
